FILE: design/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg: shared constants for the line follower pd steering core
// weights, tick counts, register indexes and direction codes with their widths
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int unsigned LOST_DELAY_TICKS = 3;
  localparam int unsigned LOST_RAMP_TICKS  = 16;
  localparam int unsigned RECOVER_TICKS    = 4;
  localparam int unsigned CROSS_HOLD_TICKS = 8;
  localparam int unsigned CROSS_MIN_COUNT  = 5;

  localparam logic [7:0] CENTER_BITS = 8'h18;

  // register indexes
  localparam logic [2:0] REG_KP_SOFT   = 3'd0;
  localparam logic [2:0] REG_KP_HARD   = 3'd1;
  localparam logic [2:0] REG_KD_GAIN   = 3'd2;
  localparam logic [2:0] REG_DEADBAND  = 3'd3;
  localparam logic [2:0] REG_MID_THR   = 3'd4;
  localparam logic [2:0] REG_HARD_THR  = 3'd5;
  localparam logic [2:0] REG_SPEED     = 3'd6;
  localparam logic [2:0] REG_SEARCH    = 3'd7;

  // last direction codes
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  // signed q4.8 sensor weight
  function automatic logic signed [12:0] weight(input logic [2:0] idx);
    logic signed [12:0] w;
    begin
      case (idx)
        3'd0: w = -13'sd2304;
        3'd1: w = -13'sd1280;
        3'd2: w = -13'sd640;
        3'd3: w = -13'sd256;
        3'd4: w = 13'sd256;
        3'd5: w = 13'sd640;
        3'd6: w = 13'sd1280;
        default: w = 13'sd2304;
      endcase
      return w;
    end
  endfunction

endpackage

FILE: design/line_follow_pd_steering_core.sv
// ----------------------------------------------------------------------------
// line_follow_pd_steering_core: line follower pd steering controller
// eight-sensor scan and decision: straight and hold results are emitted, search
// results take ramp steps while ramping, the rest a 13-step divide, and pd results then kp
// and kd products on the shared multiplier and an output step; one request at a
// time, the next request is accepted from the cycle after the result is taken.
// synchronous active-low reset clears configuration, controller state, the fsm and output valid.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_core #(
  parameter int unsigned LOST_DELAY_TICKS = lfpd_pkg::LOST_DELAY_TICKS,
  parameter int unsigned LOST_RAMP_TICKS  = lfpd_pkg::LOST_RAMP_TICKS,
  parameter int unsigned RECOVER_TICKS    = lfpd_pkg::RECOVER_TICKS,
  parameter int unsigned CROSS_HOLD_TICKS = lfpd_pkg::CROSS_HOLD_TICKS,
  parameter int unsigned CROSS_MIN_COUNT  = lfpd_pkg::CROSS_MIN_COUNT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_sensor_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left_target,
  output logic signed [15:0] out_right_target,
  output logic signed [12:0] out_position_error,
  output logic               out_line_lost,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_DIV, S_ERR, S_PD_KP, S_PD_KD, S_PD_OUT,
    S_RAMP_MUL, S_RAMP_DIV, S_RAMP_OUT, S_EMIT
  } state_t;

  localparam logic [7:0] DELAY_T = 8'(LOST_DELAY_TICKS);
  localparam logic [7:0] RAMP_T  = 8'(LOST_RAMP_TICKS);
  localparam logic [7:0] RECOV_T = 8'(RECOVER_TICKS);
  localparam logic [7:0] CROSS_T = 8'(CROSS_HOLD_TICKS);
  localparam logic [3:0] CMIN    = 4'(CROSS_MIN_COUNT);

  // reciprocal of the ramp tick count, exact for 24-bit magnitudes
  localparam int unsigned RAMP_SH = 24 + $clog2(LOST_RAMP_TICKS);
  localparam longint unsigned RECIP_L =
    ((64'd1 << RAMP_SH) + 64'(LOST_RAMP_TICKS) - 64'd1) / 64'(LOST_RAMP_TICKS);
  localparam logic [24:0] RECIP = 25'(RECIP_L);

  // configuration registers
  logic [15:0] kp_soft_r, kp_hard_r, kd_gain_r;
  logic [11:0] deadband_r, mid_thr_r, hard_thr_r;
  logic [63:0] speed_r;
  logic [47:0] search_r;

  // controller state
  logic signed [15:0] prev_err_r;
  logic [1:0]  last_dir_r;
  logic        fallback_r, lost_mode_r;
  logic [7:0]  delay_cnt_r, recover_cnt_r, ramp_cnt_r, cross_hold_r;

  // working registers
  state_t             state_r;
  logic [7:0]         bits_r;
  logic [3:0]         idx_r;
  logic [3:0]         count_r;
  logic signed [13:0] sum_r;
  logic [11:0]        rem_r;
  logic [12:0]        quo_r;
  logic [3:0]         div_cnt_r;
  logic signed [12:0] err_r;
  logic [11:0]        abs_r;
  logic signed [47:0] acc_r;
  logic signed [17:0] diff_r;
  logic               ramp_neg_r;
  logic [23:0]        ramp_mag_r;

  // output slot
  logic               out_valid_r;
  logic signed [15:0] left_r, right_r;
  logic signed [12:0] perr_r;
  logic               lost_r;

  logic signed [15:0] straight, mid_spd, hard_spd, srch_spd, srch_start, srch_end;
  logic [15:0]        limit;
  assign straight   = speed_r[15:0];
  assign mid_spd    = speed_r[31:16];
  assign hard_spd   = speed_r[47:32];
  assign limit      = speed_r[63:48];
  assign srch_spd   = search_r[15:0];
  assign srch_start = search_r[31:16];
  assign srch_end   = search_r[47:32];

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_left_target    = left_r;
  assign out_right_target   = right_r;
  assign out_position_error = perr_r;
  assign out_line_lost      = lost_r;

  // shared multiplier: one signed 26x26 product per cycle
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // divide step (restoring, magnitude)
  logic [12:0] rem_sh;
  logic [12:0] rem_sub;
  assign rem_sh  = {rem_r, quo_r[12]};
  assign rem_sub = rem_sh - {9'd0, count_r};

  logic search_pos;
  assign search_pos = (last_dir_r == lfpd_pkg::DIR_RIGHT) ? 1'b1 :
                      (last_dir_r == lfpd_pkg::DIR_LEFT) ? 1'b0 : fallback_r;

  // base speed select, rounding and clamp of the pd result
  logic signed [47:0] rnd;
  logic signed [31:0] steer;
  logic signed [17:0] base;
  logic signed [33:0] lsum, rsum, lim_p, lim_n, lcl, rcl;
  always_comb begin
    rnd   = (acc_r + 48'sd128) >>> 8;
    steer = rnd[31:0];
    if ({1'b0, abs_r} >= {1'b0, hard_thr_r}) base = 18'(hard_spd);
    else if (abs_r >= mid_thr_r) base = 18'(mid_spd);
    else base = 18'(straight);
    lsum  = 34'(base) + 34'(steer);
    rsum  = 34'(base) - 34'(steer);
    lim_p = {18'd0, limit};
    lim_n = -lim_p;
    lcl = (lsum > lim_p) ? lim_p : ((lsum < lim_n) ? lim_n : lsum);
    rcl = (rsum > lim_p) ? lim_p : ((rsum < lim_n) ? lim_n : rsum);
  end

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) return 16'sh7fff;
    if (v < -34'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PD_KP: begin
        mul_a = 26'(err_r);
        mul_b = (abs_r < mid_thr_r) ? $signed({10'd0, kp_soft_r}) :
                                      $signed({10'd0, kp_hard_r});
      end
      S_PD_KD: begin
        mul_a = 26'(err_r) - 26'(prev_err_r);
        mul_b = $signed({10'd0, kd_gain_r});
      end
      S_RAMP_MUL: begin
        mul_a = 26'(srch_end) - 26'(srch_start);
        mul_b = $signed({18'd0, ramp_cnt_r});
      end
      S_RAMP_DIV: begin
        mul_a = $signed({2'd0, ramp_mag_r});
        mul_b = $signed({1'b0, RECIP});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ramp quotient: magnitude times reciprocal, sign restored, truncates toward zero
  logic [16:0]        ramp_q;
  logic signed [17:0] ramp_qs;
  assign ramp_q  = mul_p[RAMP_SH +: 17];
  assign ramp_qs = ramp_neg_r ? -$signed({1'b0, ramp_q}) : $signed({1'b0, ramp_q});

  logic signed [12:0] quo_s;
  assign quo_s = sum_r[13] ? -$signed({1'b0, quo_r[11:0]}) : $signed({1'b0, quo_r[11:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_soft_r <= '0; kp_hard_r <= '0; kd_gain_r <= '0;
      deadband_r <= '0; mid_thr_r <= '0; hard_thr_r <= '0;
      speed_r <= '0; search_r <= '0;
      prev_err_r <= '0; last_dir_r <= lfpd_pkg::DIR_NONE; fallback_r <= 1'b0;
      lost_mode_r <= 1'b0; delay_cnt_r <= '0; recover_cnt_r <= '0;
      ramp_cnt_r <= '0; cross_hold_r <= '0;
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          lfpd_pkg::REG_KP_SOFT:  kp_soft_r  <= cfg_data[15:0];
          lfpd_pkg::REG_KP_HARD:  kp_hard_r  <= cfg_data[15:0];
          lfpd_pkg::REG_KD_GAIN:  kd_gain_r  <= cfg_data[15:0];
          lfpd_pkg::REG_DEADBAND: deadband_r <= cfg_data[11:0];
          lfpd_pkg::REG_MID_THR:  mid_thr_r  <= cfg_data[11:0];
          lfpd_pkg::REG_HARD_THR: hard_thr_r <= cfg_data[11:0];
          lfpd_pkg::REG_SPEED:    speed_r    <= cfg_data;
          lfpd_pkg::REG_SEARCH:   search_r   <= cfg_data[47:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            bits_r  <= in_sensor_bits;
            idx_r   <= '0;
            count_r <= '0;
            sum_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        // one sensor per cycle through the adder
        S_SCAN: begin
          if (bits_r[idx_r[2:0]]) begin
            count_r <= count_r + 4'd1;
            sum_r   <= sum_r + 14'(lfpd_pkg::weight(idx_r[2:0]));
          end
          if (idx_r == 4'd7) state_r <= S_DECIDE;
          idx_r <= idx_r + 4'd1;
        end
        S_DECIDE: begin
          if (count_r == 4'd0) begin
            logic [7:0] rc;
            rc = ramp_cnt_r;
            if (!lost_mode_r) begin
              lost_mode_r <= 1'b1;
              recover_cnt_r <= '0;
              rc = '0;
              ramp_cnt_r <= '0;
            end
            if (delay_cnt_r < DELAY_T) begin
              delay_cnt_r <= delay_cnt_r + 8'd1;
              left_r <= straight; right_r <= straight; perr_r <= '0; lost_r <= 1'b1;
              state_r <= S_EMIT;
            end else if (rc < RAMP_T) begin
              state_r <= S_RAMP_MUL;
            end else begin
              diff_r  <= 18'(srch_end);
              state_r <= S_RAMP_OUT;
            end
          end else if (count_r >= CMIN || cross_hold_r != 8'd0) begin
            if (count_r >= CMIN) cross_hold_r <= CROSS_T;
            else cross_hold_r <= cross_hold_r - 8'd1;
            prev_err_r <= '0;
            left_r <= straight; right_r <= straight; perr_r <= '0; lost_r <= 1'b0;
            state_r <= S_EMIT;
          end else if (lost_mode_r && recover_cnt_r < RECOV_T) begin
            recover_cnt_r <= recover_cnt_r + 8'd1;
            diff_r  <= 18'(srch_start);
            state_r <= S_RAMP_OUT;
          end else begin
            if (lost_mode_r) begin
              lost_mode_r <= 1'b0;
              recover_cnt_r <= '0;
              ramp_cnt_r <= '0;
            end
            delay_cnt_r <= '0;
            if ((bits_r & ~lfpd_pkg::CENTER_BITS) == 8'd0) begin
              prev_err_r <= '0;
              left_r <= straight; right_r <= straight; perr_r <= '0; lost_r <= 1'b0;
              state_r <= S_EMIT;
            end else begin
              rem_r     <= '0;
              quo_r     <= sum_r[13] ? 13'(-sum_r) : 13'(sum_r);
              div_cnt_r <= '0;
              state_r   <= S_DIV;
            end
          end
        end
        // restoring divide, one quotient bit per cycle
        S_DIV: begin
          if (!rem_sub[12]) begin
            rem_r <= rem_sub[11:0];
            quo_r <= {quo_r[11:0], 1'b1};
          end else begin
            rem_r <= rem_sh[11:0];
            quo_r <= {quo_r[11:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == 4'd12) state_r <= S_ERR;
        end
        // signed error, deadband check and direction memory
        S_ERR: begin
          err_r <= quo_s;
          abs_r <= quo_r[11:0];
          if (quo_r[11:0] <= deadband_r) begin
            prev_err_r <= '0;
            left_r <= straight; right_r <= straight; perr_r <= quo_s; lost_r <= 1'b0;
            state_r <= S_EMIT;
          end else begin
            last_dir_r <= quo_s[12] ? lfpd_pkg::DIR_LEFT : lfpd_pkg::DIR_RIGHT;
            fallback_r <= ~quo_s[12];
            state_r    <= S_PD_KP;
          end
        end
        S_PD_KP: begin
          acc_r   <= 48'(mul_p);
          state_r <= S_PD_KD;
        end
        S_PD_KD: begin
          acc_r   <= acc_r + 48'(mul_p);
          state_r <= S_PD_OUT;
        end
        S_PD_OUT: begin
          prev_err_r <= 16'(err_r);
          left_r  <= sat16(lcl);
          right_r <= sat16(rcl);
          perr_r  <= err_r;
          lost_r  <= 1'b0;
          state_r <= S_EMIT;
        end
        // ramp product, split into sign and magnitude; the ramp count advances
        S_RAMP_MUL: begin
          ramp_neg_r <= mul_p[51];
          ramp_mag_r <= mul_p[51] ? 24'(-mul_p) : 24'(mul_p);
          ramp_cnt_r <= ramp_cnt_r + 8'd1;
          state_r    <= S_RAMP_DIV;
        end
        S_RAMP_DIV: begin
          diff_r  <= 18'(srch_start) + ramp_qs;
          state_r <= S_RAMP_OUT;
        end
        S_RAMP_OUT: begin
          if (search_pos) begin
            left_r  <= sat16(34'(srch_spd) + 34'(diff_r));
            right_r <= sat16(34'(srch_spd) - 34'(diff_r));
          end else begin
            left_r  <= sat16(34'(srch_spd) - 34'(diff_r));
            right_r <= sat16(34'(srch_spd) + 34'(diff_r));
          end
          perr_r  <= '0;
          lost_r  <= 1'b1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/lfpd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfpd_checker: steering result checker
// mirrors register writes, predicts wheel targets for each accepted request
// and compares every accepted result field by field in arrival order
// ----------------------------------------------------------------------------
module lfpd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_sensor_bits,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_left_target,
  input  logic signed [15:0] out_right_target,
  input  logic signed [12:0] out_position_error,
  input  logic               out_line_lost,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [12:0] err;
    logic               lost;
  } steer_t;

  steer_t steer_q[$];

  // shadow registers
  longint kp_soft_r, kp_hard_r, kd_r, dead_r, mid_r, hard_r;
  logic [63:0] speed_r;
  logic [47:0] search_r;

  // shadow controller state
  longint prev_err;
  logic [1:0] last_dir;
  logic fb_dir, lost_m;
  int delay_cnt, recov_cnt, ramp_cnt, cross_cnt;

  assign pending_count = steer_q.size();

  function automatic longint fld(logic [63:0] r, int idx);
    logic signed [15:0] v;
    v = r[16*idx +: 16];
    return longint'(v);
  endfunction

  function automatic logic signed [15:0] sat(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic steer_t mk(longint l, longint r, longint e, logic lost);
    steer_t s;
    s.left = sat(l);
    s.right = sat(r);
    s.err = e[12:0];
    s.lost = lost;
    return s;
  endfunction

  function automatic steer_t search_out(longint diff);
    longint spd;
    logic pos;
    spd = fld({16'd0, search_r}, 0);
    pos = (last_dir == lfpd_pkg::DIR_RIGHT) ? 1'b1 :
          (last_dir == lfpd_pkg::DIR_LEFT) ? 1'b0 : fb_dir;
    if (pos) return mk(spd + diff, spd - diff, 0, 1'b1);
    return mk(spd - diff, spd + diff, 0, 1'b1);
  endfunction

  // predicts one result and advances the shadow state
  function automatic steer_t predict_steer(logic [7:0] bits);
    longint cnt, sum, e, ae, straight, diff, st, en, delta, kp, steer, lim, base, l, r, x;
    cnt = 0;
    sum = 0;
    for (int i = 0; i < 8; i++)
      if (bits[i]) begin
        cnt++;
        sum += longint'(lfpd_pkg::weight(i[2:0]));
      end
    straight = fld(speed_r, 0);
    // no sensor lit: delay, then ramped search
    if (cnt == 0) begin
      st = fld({16'd0, search_r}, 1);
      en = fld({16'd0, search_r}, 2);
      if (!lost_m) begin
        lost_m = 1'b1;
        recov_cnt = 0;
        ramp_cnt = 0;
      end
      if (delay_cnt < lfpd_pkg::LOST_DELAY_TICKS) begin
        delay_cnt++;
        return mk(straight, straight, 0, 1'b1);
      end
      if (ramp_cnt < lfpd_pkg::LOST_RAMP_TICKS) begin
        diff = st + ((en - st) * longint'(ramp_cnt)) / longint'(lfpd_pkg::LOST_RAMP_TICKS);
        ramp_cnt++;
      end else diff = en;
      return search_out(diff);
    end
    // crossing and its hold
    if (cnt >= lfpd_pkg::CROSS_MIN_COUNT || cross_cnt > 0) begin
      if (cnt >= lfpd_pkg::CROSS_MIN_COUNT) cross_cnt = lfpd_pkg::CROSS_HOLD_TICKS;
      else cross_cnt--;
      prev_err = 0;
      return mk(straight, straight, 0, 1'b0);
    end
    // recovery hold
    if (lost_m) begin
      if (recov_cnt < lfpd_pkg::RECOVER_TICKS) begin
        recov_cnt++;
        return search_out(fld({16'd0, search_r}, 1));
      end
      lost_m = 1'b0;
      recov_cnt = 0;
      ramp_cnt = 0;
    end
    delay_cnt = 0;
    if ((bits & ~lfpd_pkg::CENTER_BITS) == 8'd0) begin
      prev_err = 0;
      return mk(straight, straight, 0, 1'b0);
    end
    e = sum / cnt;
    ae = (e < 0) ? -e : e;
    if (ae <= dead_r) begin
      prev_err = 0;
      return mk(straight, straight, e, 1'b0);
    end
    last_dir = (e < 0) ? lfpd_pkg::DIR_LEFT : lfpd_pkg::DIR_RIGHT;
    fb_dir = (e < 0) ? 1'b0 : 1'b1;
    // pd steering
    delta = e - prev_err;
    kp = (ae < mid_r) ? kp_soft_r : kp_hard_r;
    x = kp * e + kd_r * delta + 128;
    steer = (x >= 0) ? x / 256 : -((-x + 255) / 256);
    lim = longint'(speed_r[63:48]);
    prev_err = e;
    if (ae >= hard_r) base = fld(speed_r, 2);
    else if (ae >= mid_r) base = fld(speed_r, 1);
    else base = straight;
    l = base + steer;
    r = base - steer;
    if (l > lim) l = lim;
    if (l < -lim) l = -lim;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return mk(l, r, e, 1'b0);
  endfunction

  always @(posedge clk) begin
    steer_t exp_s;
    if (!rst_n) begin
      kp_soft_r <= 0; kp_hard_r <= 0; kd_r <= 0;
      dead_r <= 0; mid_r <= 0; hard_r <= 0;
      speed_r <= '0; search_r <= '0;
      prev_err = 0; last_dir = lfpd_pkg::DIR_NONE; fb_dir = 1'b0; lost_m = 1'b0;
      delay_cnt = 0; recov_cnt = 0; ramp_cnt = 0; cross_cnt = 0;
      fail_count <= 0;
      steer_q.delete();
    end else begin
      // register write mirror
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lfpd_pkg::REG_KP_SOFT:  kp_soft_r <= longint'(cfg_data[15:0]);
          lfpd_pkg::REG_KP_HARD:  kp_hard_r <= longint'(cfg_data[15:0]);
          lfpd_pkg::REG_KD_GAIN:  kd_r <= longint'(cfg_data[15:0]);
          lfpd_pkg::REG_DEADBAND: dead_r <= longint'(cfg_data[11:0]);
          lfpd_pkg::REG_MID_THR:  mid_r <= longint'(cfg_data[11:0]);
          lfpd_pkg::REG_HARD_THR: hard_r <= longint'(cfg_data[11:0]);
          lfpd_pkg::REG_SPEED:    speed_r <= cfg_data;
          lfpd_pkg::REG_SEARCH:   search_r <= cfg_data[47:0];
          default: ;
        endcase
      end
      // accepted request
      if (in_valid && !in_stall) steer_q.push_back(predict_steer(in_sensor_bits));
      // accepted result
      if (out_valid && !out_stall) begin
        if (steer_q.size() == 0) begin
          $display("%0t: result with nothing expected: %0d %0d %0d %0b", $time,
                   out_left_target, out_right_target, out_position_error, out_line_lost);
          fail_count <= fail_count + 1;
        end else begin
          exp_s = steer_q.pop_front();
          if (exp_s.left !== out_left_target || exp_s.right !== out_right_target ||
              exp_s.err !== out_position_error || exp_s.lost !== out_line_lost) begin
            $display({"%0t: mismatch expected l=%0d r=%0d e=%0d lost=%0b",
                      " actual l=%0d r=%0d e=%0d lost=%0b"},
                     $time, exp_s.left, exp_s.right, exp_s.err, exp_s.lost,
                     out_left_target, out_right_target, out_position_error, out_line_lost);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: line follower pd steering regression
// writes register settings between phases, drives directed and random sensor
// patterns with random gaps and stalls, and reports the checker verdict
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_sensor_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_left_target, out_right_target;
  logic signed [12:0] out_position_error;
  logic out_line_lost;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int fail_count, pending_count;
  int cycle_count = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  line_follow_pd_steering_core u_top (.*);

  lfpd_checker u_chk (.*);

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);

  // valid stays high; load_all drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // idle cycles drop valid; back to back requests keep it high
  task automatic send_sensors(input logic [7:0] bits);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sensor_bits <= bits;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_all(input int mode);
    logic [63:0] v[8];
    for (int i = 0; i < 8; i++) v[i] = {$urandom, $urandom};
    if (mode == 1) begin
      v[0] = 64'hffff; v[1] = 64'hffff; v[2] = 64'hffff;
      v[3] = 64'd2304; v[4] = 64'd2304; v[5] = 64'd2304;
      v[6] = 64'hffff_7fff_8000_7fff; v[7] = 64'h7fff_8000_7fff;
    end else if (mode == 2) begin
      v[0] = 64'd300; v[1] = 64'd700; v[2] = 64'd200;
      v[3] = 64'd100; v[4] = 64'd700; v[5] = 64'd1500;
      v[6] = {16'd12000, 16'd4000, 16'd6000, 16'd8000};
      v[7] = {16'hfc00, 16'd1500, 16'd300, 16'd3000};
    end else if (mode == 3) begin
      v[3] = $urandom_range(2304); v[4] = $urandom_range(2304);
      v[5] = $urandom_range(2304);
    end
    for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
    cfg_valid <= 1'b0;
  endtask

  // track-like bits: mostly single or adjacent lit sensors, plus lost, crossing and random patterns
  function automatic logic [7:0] track_bits();
    int k;
    int p;
    k = $urandom_range(99);
    p = $urandom_range(7);
    if (k < 12) return 8'h00;
    if (k < 20) return 8'hff >> $urandom_range(3);
    if (k < 28) return 8'($urandom);
    if (k < 60) return 8'(1 << p);
    return 8'(3 << p) | 8'(1 << p);
  endfunction

  initial begin
    logic [7:0] b;
    int run;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, lost ramp, crossing hold, center, deadband
    load_all(2);
    send_sensors(8'h01); send_sensors(8'h80); send_sensors(8'h18); send_sensors(8'h08);
    send_sensors(8'h30); send_sensors(8'h03); send_sensors(8'h81);
    repeat (8) send_sensors(8'h00);
    send_sensors(8'h04); send_sensors(8'h02); send_sensors(8'h20);
    send_sensors(8'h20); send_sensors(8'h20); send_sensors(8'h20);
    send_sensors(8'hff); send_sensors(8'h1f); send_sensors(8'h02); send_sensors(8'h40);
    drain_wait();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      load_all(ph == 0 ? 1 : (ph == 5 ? 0 : 3));
      calm = (ph == 2);
      for (int n = 0; n < 40; n++) begin
        b = track_bits();
        run = (b == 8'h00) ? $urandom_range(25) : ((b == 8'hff) ? 10 : 1);
        if (n % 17 == 3) b = 8'($urandom);
        for (int r = 0; r < run && r < 30; r++) send_sensors(b);
      end
      calm = 1'b0;
      drain_wait();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lfpd_pkg.sv
design/line_follow_pd_steering_core.sv
tb/lfpd_checker.sv
tb/testbench.sv
